[rtl/nfec_pkg.sv]
// Shared types, constants and helper functions for the Newton fractal escape counter.
package nfec_pkg;

  localparam int CW         = 32;
  localparam int FB         = 28;
  localparam int PW         = 2 * CW;
  localparam int SHW        = PW - FB;
  localparam int AW         = SHW + 1;
  localparam int DVW        = PW - FB;
  localparam int DIV_CNT_W  = $clog2(PW + 1);
  localparam int DEG_W      = 5;
  localparam int MAX_DEGREE = 16;
  localparam int ITER_W     = 16;
  localparam int EPS_W      = 29;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef struct packed {
    logic signed [CW-1:0] point_re;
    logic signed [CW-1:0] point_im;
  } point_t;

  typedef struct packed {
    logic [ITER_W-1:0] iterations;
    logic              zero_derivative;
  } result_t;

  typedef struct packed {
    logic                 mode;
    logic signed [CW-1:0] const_re;
    logic signed [CW-1:0] const_im;
    logic signed [CW-1:0] lin_re;
    logic signed [CW-1:0] lin_im;
    logic [DEG_W-1:0]     degree;
    logic [ITER_W-1:0]    iteration_limit;
    logic [EPS_W-1:0]     eps;
  } cfg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_CONST_RE = 3'd1,
    REG_CONST_IM = 3'd2,
    REG_LIN_RE   = 3'd3,
    REG_LIN_IM   = 3'd4,
    REG_DEGREE   = 3'd5,
    REG_LIMIT    = 3'd6,
    REG_EPS      = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    MS_WR_X, MS_WI_Y, MS_WR_Y, MS_WI_X,
    MS_N_WR, MS_N_WI,
    MS_LR_X, MS_LI_Y, MS_LR_Y, MS_LI_X,
    MS_DR_DR, MS_DI_DI,
    MS_NR_DR, MS_NI_DI, MS_NI_DR, MS_NR_DI
  } mul_sel_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT_W,
    OP_RE_SET,
    OP_RE_ADD,
    OP_RE_SUB,
    OP_IM_SET,
    OP_IM_ADD,
    OP_IM_SUB,
    OP_COMMIT_W,
    OP_COMMIT_ZN,
    OP_DR,
    OP_DI,
    OP_COMMIT_N,
    OP_MAG_SET,
    OP_MAG_ADD,
    OP_DIVISOR,
    OP_DIV_RE,
    OP_TR,
    OP_DIV_IM,
    OP_TI,
    OP_UPD
  } dp_op_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    dp_op_t   op;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_d;
    logic conv;
    logic div_done;
  } dp_stat_t;

  function automatic logic signed [CW-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [CW-1:0] r;
    if (v[PW-1:CW-1] == {(PW-CW+1){v[PW-1]}}) begin
      r = v[CW-1:0];
    end else if (v[PW-1]) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [DEG_W-1:0] clamp_degree(input logic [DEG_W-1:0] d);
    logic [DEG_W-1:0] r;
    if (d < DEG_W'(2)) begin
      r = DEG_W'(2);
    end else if (d > DEG_W'(MAX_DEGREE)) begin
      r = DEG_W'(MAX_DEGREE);
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

[rtl/nfec_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
module nfec_div import nfec_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [PW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic [PW-1:0]  quotient,
  output logic           done
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVW-1:0]       rem;
  logic [DVW-1:0]       dvs;
  logic [PW-1:0]        dvd;
  logic [DVW:0]         trial;
  logic                 ge;

  always_comb begin
    trial = {rem, dvd[PW-1]};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(PW);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? DVW'(trial - {1'b0, dvs}) : DVW'(trial);
      dvd <= {dvd[PW-2:0], ge};
    end
  end

  assign quotient = dvd;

endmodule

[rtl/nfec_dpath.sv]
// Datapath: coordinate registers, shared multiplier, accumulators and divider.
module nfec_dpath import nfec_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  point_t   point,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat
);

  logic signed [CW-1:0]  x, y, cr, ci, wr, wi, znr, zni, dr, di, nr, ni, tr, ti;
  logic signed [CW-1:0]  ma, mb, nop, xn, yn;
  logic signed [PW-1:0]  mp, prod;
  logic signed [SHW-1:0] sh;
  logic signed [AW-1:0]  acc_re, acc_im, num;
  logic [PW-1:0]         mag;
  logic [DVW-1:0]        divisor;
  logic [AW-1:0]         num_abs;
  logic [PW-1:0]         dividend, quot;
  logic                  div_start, div_done, conv;
  logic signed [CW:0]    dx, dy;
  logic [CW:0]           adx, ady;

  function automatic logic signed [CW-1:0] qfix(input logic [PW-1:0] q, input logic neg);
    logic [CW-1:0]      cap;
    logic [CW-1:0]      qc;
    logic signed [CW:0] sv;
    cap = {1'b1, {(CW-1){1'b0}}};
    qc  = (q > {{(PW-CW){1'b0}}, cap}) ? cap : q[CW-1:0];
    sv  = neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    return sat(PW'(sv));
  endfunction

  assign nop = $signed(CW'(clamp_degree(cfg.degree)));

  always_comb begin
    case (cmd.mul_sel)
      MS_WR_X:  begin ma = wr;         mb = x;  end
      MS_WI_Y:  begin ma = wi;         mb = y;  end
      MS_WR_Y:  begin ma = wr;         mb = y;  end
      MS_WI_X:  begin ma = wi;         mb = x;  end
      MS_N_WR:  begin ma = nop;        mb = wr; end
      MS_N_WI:  begin ma = nop;        mb = wi; end
      MS_LR_X:  begin ma = cfg.lin_re; mb = x;  end
      MS_LI_Y:  begin ma = cfg.lin_im; mb = y;  end
      MS_LR_Y:  begin ma = cfg.lin_re; mb = y;  end
      MS_LI_X:  begin ma = cfg.lin_im; mb = x;  end
      MS_DR_DR: begin ma = dr;         mb = dr; end
      MS_DI_DI: begin ma = di;         mb = di; end
      MS_NR_DR: begin ma = nr;         mb = dr; end
      MS_NI_DI: begin ma = ni;         mb = di; end
      MS_NI_DR: begin ma = ni;         mb = dr; end
      MS_NR_DI: begin ma = nr;         mb = di; end
      default:  begin ma = wr;         mb = x;  end
    endcase
  end

  assign mp = ma * mb;

  always_ff @(posedge clk) begin
    prod <= mp;
  end

  assign sh = SHW'(prod >>> FB);

  always_comb begin
    num       = (cmd.op == OP_DIV_IM) ? acc_im : acc_re;
    num_abs   = num[AW-1] ? AW'(-num) : AW'(num);
    dividend  = {num_abs[DVW-1:0], {FB{1'b0}}};
    div_start = (cmd.op == OP_DIV_RE) || (cmd.op == OP_DIV_IM);
    xn        = sat(PW'(x) - PW'(tr));
    yn        = sat(PW'(y) - PW'(ti));
    dx        = (CW+1)'(x) - (CW+1)'(xn);
    dy        = (CW+1)'(y) - (CW+1)'(yn);
    adx       = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
    ady       = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        if (cfg.mode) begin
          x  <= '0;
          y  <= '0;
          cr <= point.point_re;
          ci <= point.point_im;
        end else begin
          x  <= point.point_re;
          y  <= point.point_im;
          cr <= cfg.const_re;
          ci <= cfg.const_im;
        end
      end
      OP_INIT_W: begin
        wr <= x;
        wi <= y;
      end
      OP_RE_SET:    acc_re <= AW'(sh);
      OP_RE_ADD:    acc_re <= acc_re + AW'(sh);
      OP_RE_SUB:    acc_re <= acc_re - AW'(sh);
      OP_IM_SET:    acc_im <= AW'(sh);
      OP_IM_ADD:    acc_im <= acc_im + AW'(sh);
      OP_IM_SUB:    acc_im <= acc_im - AW'(sh);
      OP_COMMIT_W: begin
        wr <= sat(PW'(acc_re));
        wi <= sat(PW'(acc_im));
      end
      OP_COMMIT_ZN: begin
        znr <= sat(PW'(acc_re));
        zni <= sat(PW'(acc_im));
      end
      OP_DR:        dr <= sat(PW'(sat(prod)) + PW'(cfg.lin_re));
      OP_DI:        di <= sat(PW'(sat(prod)) + PW'(cfg.lin_im));
      OP_COMMIT_N: begin
        nr <= sat(PW'(znr) + PW'(sat(PW'(acc_re))) + PW'(cr));
        ni <= sat(PW'(zni) + PW'(sat(PW'(acc_im))) + PW'(ci));
      end
      OP_MAG_SET:   mag <= $unsigned(prod);
      OP_MAG_ADD:   mag <= mag + $unsigned(prod);
      OP_DIVISOR:   divisor <= (mag[PW-1:FB] == '0) ? DVW'(1) : mag[PW-1:FB];
      OP_TR:        tr <= qfix(quot, acc_re[AW-1]);
      OP_TI:        ti <= qfix(quot, acc_im[AW-1]);
      OP_UPD: begin
        x    <= xn;
        y    <= yn;
        conv <= (adx < (CW+1)'(cfg.eps)) && (ady < (CW+1)'(cfg.eps));
      end
      default: ;
    endcase
  end

  nfec_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quot),
    .done     (div_done)
  );

  always_comb begin
    stat.zero_d   = (dr == '0) && (di == '0);
    stat.conv     = conv;
    stat.div_done = div_done;
  end

endmodule

[rtl/nfec_ctrl.sv]
// Controller: sequences the Newton iteration over the shared datapath.
module nfec_ctrl import nfec_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     point_valid,
  input  logic     emit_ok,
  input  dp_stat_t stat,
  output logic     idle,
  output logic     emit,
  output result_t  res,
  output dp_cmd_t  cmd
);

  localparam int ST_W = 29;

  typedef enum logic [ST_W-1:0] {
    S_IDLE = ST_W'(1) << 0,
    S_TEST = ST_W'(1) << 1,
    S_PW0  = ST_W'(1) << 2,
    S_PW1  = ST_W'(1) << 3,
    S_PW2  = ST_W'(1) << 4,
    S_PW3  = ST_W'(1) << 5,
    S_PWC  = ST_W'(1) << 6,
    S_DR   = ST_W'(1) << 7,
    S_DI   = ST_W'(1) << 8,
    S_DCHK = ST_W'(1) << 9,
    S_Q0   = ST_W'(1) << 10,
    S_Q1   = ST_W'(1) << 11,
    S_Q2   = ST_W'(1) << 12,
    S_Q3   = ST_W'(1) << 13,
    S_QC   = ST_W'(1) << 14,
    S_M0   = ST_W'(1) << 15,
    S_M1   = ST_W'(1) << 16,
    S_MDIV = ST_W'(1) << 17,
    S_N0   = ST_W'(1) << 18,
    S_N1   = ST_W'(1) << 19,
    S_N2   = ST_W'(1) << 20,
    S_N3   = ST_W'(1) << 21,
    S_DVR  = ST_W'(1) << 22,
    S_WRE  = ST_W'(1) << 23,
    S_DVI  = ST_W'(1) << 24,
    S_WIM  = ST_W'(1) << 25,
    S_UPD  = ST_W'(1) << 26,
    S_CHK  = ST_W'(1) << 27,
    S_DONE = ST_W'(1) << 28
  } state_t;

  state_t            state, state_next;
  logic              phase;
  logic              is_mul;
  logic [ITER_W-1:0] iter;
  logic              flag;
  logic [DEG_W-1:0]  pcnt;

  always_comb begin
    is_mul = state inside {S_PW0, S_PW1, S_PW2, S_PW3, S_DR, S_DI, S_Q0, S_Q1, S_Q2, S_Q3,
                           S_M0, S_M1, S_N0, S_N1, S_N2, S_N3};
  end

  always_comb begin
    cmd.mul_sel = MS_WR_X;
    cmd.op      = OP_NONE;
    state_next  = state;
    emit        = 1'b0;
    case (state)
      S_IDLE: begin
        if (point_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (iter >= cfg.iteration_limit) begin
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_INIT_W;
          state_next = S_PW0;
        end
      end
      S_PW0: begin
        cmd.mul_sel = MS_WR_X;
        if (phase) begin cmd.op = OP_RE_SET; state_next = S_PW1; end
      end
      S_PW1: begin
        cmd.mul_sel = MS_WI_Y;
        if (phase) begin cmd.op = OP_RE_SUB; state_next = S_PW2; end
      end
      S_PW2: begin
        cmd.mul_sel = MS_WR_Y;
        if (phase) begin cmd.op = OP_IM_SET; state_next = S_PW3; end
      end
      S_PW3: begin
        cmd.mul_sel = MS_WI_X;
        if (phase) begin cmd.op = OP_IM_ADD; state_next = S_PWC; end
      end
      S_PWC: begin
        if (pcnt == '0) begin
          cmd.op     = OP_COMMIT_ZN;
          state_next = S_DR;
        end else begin
          cmd.op     = OP_COMMIT_W;
          state_next = S_PW0;
        end
      end
      S_DR: begin
        cmd.mul_sel = MS_N_WR;
        if (phase) begin cmd.op = OP_DR; state_next = S_DI; end
      end
      S_DI: begin
        cmd.mul_sel = MS_N_WI;
        if (phase) begin cmd.op = OP_DI; state_next = S_DCHK; end
      end
      S_DCHK: begin
        state_next = stat.zero_d ? S_DONE : S_Q0;
      end
      S_Q0: begin
        cmd.mul_sel = MS_LR_X;
        if (phase) begin cmd.op = OP_RE_SET; state_next = S_Q1; end
      end
      S_Q1: begin
        cmd.mul_sel = MS_LI_Y;
        if (phase) begin cmd.op = OP_RE_SUB; state_next = S_Q2; end
      end
      S_Q2: begin
        cmd.mul_sel = MS_LR_Y;
        if (phase) begin cmd.op = OP_IM_SET; state_next = S_Q3; end
      end
      S_Q3: begin
        cmd.mul_sel = MS_LI_X;
        if (phase) begin cmd.op = OP_IM_ADD; state_next = S_QC; end
      end
      S_QC: begin
        cmd.op     = OP_COMMIT_N;
        state_next = S_M0;
      end
      S_M0: begin
        cmd.mul_sel = MS_DR_DR;
        if (phase) begin cmd.op = OP_MAG_SET; state_next = S_M1; end
      end
      S_M1: begin
        cmd.mul_sel = MS_DI_DI;
        if (phase) begin cmd.op = OP_MAG_ADD; state_next = S_MDIV; end
      end
      S_MDIV: begin
        cmd.op     = OP_DIVISOR;
        state_next = S_N0;
      end
      S_N0: begin
        cmd.mul_sel = MS_NR_DR;
        if (phase) begin cmd.op = OP_RE_SET; state_next = S_N1; end
      end
      S_N1: begin
        cmd.mul_sel = MS_NI_DI;
        if (phase) begin cmd.op = OP_RE_ADD; state_next = S_N2; end
      end
      S_N2: begin
        cmd.mul_sel = MS_NI_DR;
        if (phase) begin cmd.op = OP_IM_SET; state_next = S_N3; end
      end
      S_N3: begin
        cmd.mul_sel = MS_NR_DI;
        if (phase) begin cmd.op = OP_IM_SUB; state_next = S_DVR; end
      end
      S_DVR: begin
        cmd.op     = OP_DIV_RE;
        state_next = S_WRE;
      end
      S_WRE: begin
        if (stat.div_done) begin
          cmd.op     = OP_TR;
          state_next = S_DVI;
        end
      end
      S_DVI: begin
        cmd.op     = OP_DIV_IM;
        state_next = S_WIM;
      end
      S_WIM: begin
        if (stat.div_done) begin
          cmd.op     = OP_TI;
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.op     = OP_UPD;
        state_next = S_CHK;
      end
      S_CHK: begin
        state_next = stat.conv ? S_DONE : S_TEST;
      end
      S_DONE: begin
        if (emit_ok) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 1'b0;
      iter  <= '0;
      flag  <= 1'b0;
      pcnt  <= '0;
    end else begin
      state <= state_next;
      phase <= is_mul ? !phase : 1'b0;
      case (state)
        S_IDLE: begin
          if (point_valid) begin
            iter <= ITER_W'(1);
            flag <= 1'b0;
          end
        end
        S_TEST: pcnt <= clamp_degree(cfg.degree) - DEG_W'(2);
        S_PWC:  if (pcnt != '0) pcnt <= pcnt - DEG_W'(1);
        S_DCHK: if (stat.zero_d) flag <= 1'b1;
        S_CHK:  if (!stat.conv) iter <= iter + ITER_W'(1);
        default: ;
      endcase
    end
  end

  assign idle               = (state == S_IDLE);
  assign res.iterations      = iter;
  assign res.zero_derivative = flag;

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && !emit_ok |=> (state == S_DONE) && $stable(iter) && $stable(flag))
    else $error("result changed while waiting to be delivered");

  a_take_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && point_valid |=> (state == S_TEST) && (iter == ITER_W'(1)) && !flag)
    else $error("accepted point did not start a fresh count");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    (state == S_DCHK) && stat.zero_d |=> flag && (state == S_DONE))
    else $error("zero derivative not flagged");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    emit |-> res.iterations != '0)
    else $error("emitted a zero count");

endmodule

[rtl/newton_fractal_escape_count.sv]
// Top level: configuration registers, result register, controller and datapath.
//
// Usage: write the eight configuration registers on the cfg channel (index
// 0..7, always ready) while the block is idle. Send one point per beat on the
// point channel; each point yields one result beat with the iteration count
// and the zero-derivative flag.
// One point is processed at a time. Each Newton iteration uses one shared
// 32x32 multiplier for every product and two restoring divisions.
// point_stall is low only while the controller is idle; a finished result
// moves to the output register, so the next point is taken while the result
// waits. When result_stall is high the output register holds its beat, and a
// newly finished result waits in the controller until the register frees.
// Reset (rst, synchronous) returns the controller to idle, empties the
// output register and restores the register defaults.
module newton_fractal_escape_count import nfec_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  point_valid,
  output logic                  point_stall,
  input  point_t                point,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  result_t  res;
  logic     idle, emit, emit_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode            <= 1'b0;
      cfg.const_re        <= '0;
      cfg.const_im        <= '0;
      cfg.lin_re          <= '0;
      cfg.lin_im          <= '0;
      cfg.degree          <= DEG_W'(3);
      cfg.iteration_limit <= ITER_W'(256);
      cfg.eps             <= EPS_W'(268);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_MODE:     cfg.mode            <= cfg_data[0];
        REG_CONST_RE: cfg.const_re        <= $signed(cfg_data[CW-1:0]);
        REG_CONST_IM: cfg.const_im        <= $signed(cfg_data[CW-1:0]);
        REG_LIN_RE:   cfg.lin_re          <= $signed(cfg_data[CW-1:0]);
        REG_LIN_IM:   cfg.lin_im          <= $signed(cfg_data[CW-1:0]);
        REG_DEGREE:   cfg.degree          <= cfg_data[DEG_W-1:0];
        REG_LIMIT:    cfg.iteration_limit <= cfg_data[ITER_W-1:0];
        REG_EPS:      cfg.eps             <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  assign point_stall = !idle;
  assign emit_ok     = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= res;
    end
  end

  nfec_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .point_valid (point_valid),
    .emit_ok     (emit_ok),
    .stat        (stat),
    .idle        (idle),
    .emit        (emit),
    .res         (res),
    .cmd         (cmd)
  );

  nfec_dpath u_dpath (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .point (point),
    .cmd   (cmd),
    .stat  (stat)
  );

endmodule
